// ===== rtl/lsu_pkg.sv =====
// Package for the link setup SET/UA handshake block.
// Holds the payload, command and configuration types and the frame constants.
// No dependencies.
`default_nettype none

package lsu_pkg;

  localparam logic [7:0] FrameFlag = 8'h7E;
  localparam int unsigned FrameLen = 5;
  localparam int unsigned BeatW = 3;

  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpRxByte = 2'd1,
    OpTick   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhWait   = 3'd1,
    PhOk     = 3'd2,
    PhBad    = 3'd3,
    PhGaveUp = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    CfgTimeoutTicks = 3'd0,
    CfgMaxAttempts  = 3'd1,
    CfgAddressByte  = 3'd2,
    CfgSetControl   = 3'd3,
    CfgUaControl    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [7:0] timeout_ticks;
    logic [3:0] max_attempts;
    logic [7:0] address_byte;
    logic [7:0] set_control;
    logic [7:0] ua_control;
  } cfg_t;

  // One queued command: either a full SET frame or a single status beat.
  typedef struct packed {
    logic       send_frame;
    logic [2:0] status;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lsu_front.sv =====
// Front end of the link setup block: accepts input beats, runs the session
// state (timer, attempts, UA matching) and queues one command per beat.
// Depends on lsu_pkg.
`default_nettype none

module lsu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lsu_pkg::in_t  in_data_i,
  input  wire lsu_pkg::cfg_t cfg_i,
  input  wire logic          full_i,
  output logic               push_o,
  output lsu_pkg::cmd_t      cmd_o
);

  lsu_pkg::phase_e phase_q, phase_d;
  logic [2:0] pos_q, pos_d;
  logic [7:0] check_q, check_d;
  logic [3:0] attempts_q, attempts_d;
  logic [7:0] ticks_q, ticks_d;
  logic       armed_q, armed_d;

  logic       accept;
  logic       send;
  logic       ok;
  logic [7:0] limit;
  logic [3:0] tries;
  logic [7:0] tick_inc;
  logic [7:0] rx;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;
  assign rx         = in_data_i.rx_byte;
  assign limit      = (cfg_i.timeout_ticks == 8'd0) ? 8'd1 : cfg_i.timeout_ticks;
  assign tries      = (cfg_i.max_attempts == 4'd0) ? 4'd1 : cfg_i.max_attempts;
  assign tick_inc   = ticks_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    check_d    = check_q;
    attempts_d = attempts_q;
    ticks_d    = ticks_q;
    armed_d    = armed_q;
    send       = 1'b0;
    ok         = 1'b0;
    if (accept) begin
      if (in_data_i.opcode == lsu_pkg::OpStart) begin
        pos_d      = 3'd0;
        check_d    = 8'd0;
        attempts_d = 4'd1;
        ticks_d    = 8'd0;
        armed_d    = 1'b1;
        phase_d    = lsu_pkg::PhWait;
        send       = 1'b1;
      end else if (phase_q == lsu_pkg::PhWait) begin
        if (in_data_i.opcode == lsu_pkg::OpRxByte) begin
          armed_d = 1'b0;
          ticks_d = 8'd0;
          case (pos_q)
            3'd0: ok = (rx == lsu_pkg::FrameFlag);
            3'd1: begin
              ok = (rx == cfg_i.address_byte);
              if (ok) check_d = cfg_i.address_byte;
            end
            3'd2: begin
              ok = (rx == cfg_i.ua_control);
              if (ok) check_d = check_q ^ cfg_i.ua_control;
            end
            3'd3: ok = (rx == check_q);
            default: ok = (rx == lsu_pkg::FrameFlag);
          endcase
          if (pos_q >= 3'd4) begin
            phase_d = ok ? lsu_pkg::PhOk : lsu_pkg::PhBad;
          end else if (ok) begin
            pos_d = pos_q + 3'd1;
          end else begin
            phase_d = lsu_pkg::PhBad;
          end
        end else if (in_data_i.opcode == lsu_pkg::OpTick && armed_q) begin
          ticks_d = tick_inc;
          if (tick_inc >= limit) begin
            if (attempts_q >= tries) begin
              armed_d = 1'b0;
              ticks_d = 8'd0;
              phase_d = lsu_pkg::PhGaveUp;
            end else begin
              // Timeout with attempts left: resend without touching the matcher.
              attempts_d = attempts_q + 4'd1;
              ticks_d    = 8'd0;
              armed_d    = 1'b1;
              phase_d    = lsu_pkg::PhWait;
              send       = 1'b1;
            end
          end
        end
      end
    end
    cmd_o.send_frame = send;
    cmd_o.status     = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= lsu_pkg::PhIdle;
      pos_q      <= 3'd0;
      check_q    <= 8'd0;
      attempts_q <= 4'd0;
      ticks_q    <= 8'd0;
      armed_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      check_q    <= check_d;
      attempts_q <= attempts_d;
      ticks_q    <= ticks_d;
      armed_q    <= armed_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 3'd4)
    else $error("match position beyond the closing flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (phase_q == lsu_pkg::PhWait))
    else $error("timer armed outside the waiting phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.send_frame |-> (cmd_o.status == lsu_pkg::PhWait))
    else $error("frame queued without entering the waiting phase");

endmodule

`default_nettype wire

// ===== rtl/lsu_fifo.sv =====
// Short command queue between the front end and the frame serializer.
// Register-based, one push and one pop port. Depends on lsu_pkg.
`default_nettype none

module lsu_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lsu_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output lsu_pkg::cmd_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lsu_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!do_push && do_pop) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not drop on a pop");

endmodule

`default_nettype wire

// ===== rtl/lsu_back.sv =====
// Back end of the link setup block: turns queued commands into output beats,
// five for a SET frame and one for a status report. Depends on lsu_pkg.
`default_nettype none

module lsu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lsu_pkg::cfg_t cfg_i,
  input  wire logic          head_valid_i,
  input  wire lsu_pkg::cmd_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lsu_pkg::out_t      out_data_o
);

  localparam logic [lsu_pkg::BeatW-1:0] LastBeat = lsu_pkg::BeatW'(lsu_pkg::FrameLen - 1);

  logic [lsu_pkg::BeatW-1:0] beat_q, beat_d;
  logic          out_valid_q, out_valid_d;
  lsu_pkg::out_t out_q, out_d;
  logic          out_free;
  logic          emit;
  logic [7:0]    frame_byte;
  logic          last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = out_free && head_valid_i;
  assign last     = !head_i.send_frame || (beat_q == LastBeat);
  assign pop_o    = emit && last;

  always_comb begin
    case (beat_q)
      3'd0:    frame_byte = lsu_pkg::FrameFlag;
      3'd1:    frame_byte = cfg_i.address_byte;
      3'd2:    frame_byte = cfg_i.set_control;
      3'd3:    frame_byte = cfg_i.address_byte ^ cfg_i.set_control;
      default: frame_byte = lsu_pkg::FrameFlag;
    endcase
  end

  always_comb begin
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = head_valid_i;
    end
    if (emit) begin
      out_d.tx_valid    = head_i.send_frame;
      out_d.tx_byte     = head_i.send_frame ? frame_byte : 8'd0;
      out_d.status      = head_i.status;
      out_d.last_of_run = last;
      beat_d            = last ? '0 : beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q <= LastBeat)
    else $error("frame beat counter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != '0) |-> (head_valid_i && head_i.send_frame))
    else $error("frame command left the queue mid-frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.tx_valid) |-> out_q.last_of_run)
    else $error("status beat not marked as last");

endmodule

`default_nettype wire

// ===== rtl/link_setup_set_ua_handshake.sv =====
// Top level of the SET/UA link setup sender: configuration registers,
// front end, command queue and frame serializer.
// Depends on lsu_pkg, lsu_front, lsu_fifo and lsu_back.
//
//   channel  | valid / accept        | payload
//   ---------+-----------------------+-------------------------------
//   in       | in_valid_i, in_stall_o | in_data_i  (opcode, rx_byte)
//   out      | out_valid_o, out_stall_i | out_data_o (tx_valid, tx_byte,
//            |                       |   status, last_of_run)
//   config   | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// A received byte or tick passes through the front end and yields one output
// beat; a start or resend yields five beats, one per cycle while out_stall_i
// is low, from the frame serializer, which sets the sustained rate for frames.
// The queue holds FifoDepth commands, so input keeps flowing while a frame
// drains or the output is stalled; in_stall_o rises only when it is full.
// With the queue empty, an accepted input beat is written into the queue and
// then registered in the serializer's output register before it is presented.
// Reset is asynchronous and clears the session and restores the register defaults.
`default_nettype none

module link_setup_set_ua_handshake #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lsu_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lsu_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [7:0]    cfg_wdata_i
);

  lsu_pkg::cfg_t cfg_q, cfg_d;
  logic          push;
  lsu_pkg::cmd_t push_cmd;
  logic          full;
  logic          pop;
  logic          head_valid;
  lsu_pkg::cmd_t head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lsu_pkg::CfgTimeoutTicks: cfg_d.timeout_ticks = cfg_wdata_i;
        lsu_pkg::CfgMaxAttempts:  cfg_d.max_attempts  = cfg_wdata_i[3:0];
        lsu_pkg::CfgAddressByte:  cfg_d.address_byte  = cfg_wdata_i;
        lsu_pkg::CfgSetControl:   cfg_d.set_control   = cfg_wdata_i;
        lsu_pkg::CfgUaControl:    cfg_d.ua_control    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= 8'd3;
      cfg_q.max_attempts  <= 4'd3;
      cfg_q.address_byte  <= 8'h03;
      cfg_q.set_control   <= 8'h03;
      cfg_q.ua_control    <= 8'h07;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  lsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
